>>> rtl/qau_pkg.sv
package qau_pkg;

    // Default widths of every fixed-point value
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Depth of the request queue and of the result queue
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_QDIV   = 4'd3,
        OP_SCALE  = 4'd4,
        OP_SDIV   = 4'd5,
        OP_CONJ   = 4'd6,
        OP_INV    = 4'd7,
        OP_MAG    = 4'd8,
        OP_MATRIX = 4'd9
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    // Per-request control that travels with the data
    typedef struct packed {
        t_opcode op;
        logic    divz;
        logic    sat;
    } t_ctrl;

endpackage

>>> rtl/qau_fifo.sv
module qau_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_push && !o_full;
    assign rd_ok   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_ok && !rd_ok |=> !o_empty)
        else $error("queue empty after a lone push");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_ok && !wr_ok && r_cnt == CW'(1) |=> o_empty)
        else $error("queue not empty after last pop");
`endif

endmodule

>>> rtl/qau_front.sv
module qau_front #(
    parameter int D     = qau_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = qau_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [3:0]          i_opcode,
    input  logic [3:0][D-1:0]   i_a,
    input  logic [3:0][D-1:0]   i_b,
    input  logic [D-1:0]        i_s,
    output logic                o_valid,
    input  logic                i_take,
    output qau_pkg::t_ctrl      o_ctrl,
    output logic [3:0][D-1:0]   o_a,
    output logic [3:0][D-1:0]   o_b,
    output logic [D-1:0]        o_s
);

    localparam int W = $bits(qau_pkg::t_ctrl) + 9 * D;

    qau_pkg::t_ctrl ctrl;
    logic [W-1:0]   wr_data, rd_data;
    logic           empty;

    // Classify the request; a zero scalar divisor is known right away
    always_comb begin
        ctrl      = '0;
        ctrl.op   = qau_pkg::t_opcode'(i_opcode);
        ctrl.divz = (i_opcode == qau_pkg::OP_SDIV) && (i_s == '0);
        ctrl.sat  = 1'b0;
    end

    assign wr_data = {ctrl, i_a, i_b, i_s};

    qau_fifo #(
        .W     (W),
        .DEPTH (DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (wr_data),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (rd_data),
        .o_empty (empty)
    );

    assign o_valid = !empty;
    assign {o_ctrl, o_a, o_b, o_s} = rd_data;

endmodule

>>> rtl/qau_divsqrt.sv
module qau_divsqrt #(
    parameter int D      = qau_pkg::DATA_WIDTH_DEF,
    parameter int F      = qau_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [3:0][D+F-1:0]     i_num,
    input  logic [2*D-F:0]          i_den,
    input  logic [2*D+1:0]          i_rad,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [3:0][D+F-1:0]     o_quo,
    output logic [D:0]              o_root,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int QW  = D + F;
    localparam int NW  = 2 * D - F + 1;
    localparam int SQ  = D + 1;
    localparam int RW  = SQ + 3;
    localparam int NIT = QW;

    logic                  r_v    [NIT+1];
    logic [3:0][QW-1:0]    r_nq   [NIT+1];
    logic [3:0][NW-1:0]    r_rem  [NIT+1];
    logic [NW-1:0]         r_den  [NIT+1];
    logic [2*SQ-1:0]       r_rad  [NIT+1];
    logic [RW-1:0]         r_srem [NIT+1];
    logic [SQ-1:0]         r_root [NIT+1];
    logic [SIDE_W-1:0]     r_side [NIT+1];

    // Load the operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nq[0]   <= i_num;
            r_rem[0]  <= '0;
            r_den[0]  <= i_den;
            r_rad[0]  <= i_rad;
            r_srem[0] <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    // One quotient bit per lane per stage, a root bit if k < SQ
    for (genvar k = 0; k < NIT; k++) begin : g_stage
        logic [3:0][NW:0]   t_div;
        logic [3:0][QW-1:0] n_nq;
        logic [3:0][NW-1:0] n_rem;
        logic [2*SQ-1:0]    n_rad;
        logic [RW-1:0]      n_srem;
        logic [SQ-1:0]      n_root;
        logic [RW-1:0]      t_sq;
        logic [RW-1:0]      trial;

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                t_div[l] = {r_rem[k][l], r_nq[k][l][QW-1]};
                if (t_div[l] >= {1'b0, r_den[k]}) begin
                    n_rem[l] = NW'(t_div[l] - {1'b0, r_den[k]});
                    n_nq[l]  = {r_nq[k][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[l] = t_div[l][NW-1:0];
                    n_nq[l]  = {r_nq[k][l][QW-2:0], 1'b0};
                end
            end
        end

        if (k < SQ) begin : g_sqrt
            always_comb begin
                t_sq  = {r_srem[k][RW-3:0], r_rad[k][2*SQ-1 -: 2]};
                trial = RW'({r_root[k], 2'b01});
                n_rad = r_rad[k] << 2;
                if (t_sq >= trial) begin
                    n_srem = t_sq - trial;
                    n_root = {r_root[k][SQ-2:0], 1'b1};
                end else begin
                    n_srem = t_sq;
                    n_root = {r_root[k][SQ-2:0], 1'b0};
                end
            end
        end else begin : g_hold
            always_comb begin
                t_sq   = '0;
                trial  = '0;
                n_rad  = r_rad[k];
                n_srem = r_srem[k];
                n_root = r_root[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k+1]   <= n_nq;
                r_rem[k+1]  <= n_rem;
                r_den[k+1]  <= r_den[k];
                r_rad[k+1]  <= n_rad;
                r_srem[k+1] <= n_srem;
                r_root[k+1] <= n_root;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_v[NIT];
    assign o_quo   = r_nq[NIT];
    assign o_root  = r_root[NIT];
    assign o_side  = r_side[NIT];

endmodule

>>> rtl/qau_back.sv
module qau_back #(
    parameter int D = qau_pkg::DATA_WIDTH_DEF,
    parameter int F = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  qau_pkg::t_ctrl      i_ctrl,
    input  logic [3:0][D-1:0]   i_a,
    input  logic [3:0][D-1:0]   i_b,
    input  logic [D-1:0]        i_s,
    output logic                o_valid,
    output qau_pkg::t_status    o_status,
    output logic [8:0][D-1:0]   o_res
);

    localparam int QW = D + F;
    localparam int NW = 2 * D - F + 1;
    localparam int SQ = D + 1;
    localparam int PW = 2 * D;
    localparam int EW = 2 * D - F + 4;
    localparam int CTW = $bits(qau_pkg::t_ctrl);
    localparam int SIDE_W = CTW + 9 * D + 4;

    localparam logic [D-1:0] DMAXU = {1'b0, {(D-1){1'b1}}};
    localparam logic [D-1:0] DMINU = {1'b1, {(D-1){1'b0}}};
    localparam logic signed [EW-1:0] EMAX = EW'($signed(DMAXU));
    localparam logic signed [EW-1:0] EMIN = EW'($signed(DMINU));
    localparam logic signed [EW-1:0] ONE_E = EW'(1) << F;

    // Subtracted terms of the Hamilton product, bit 4*row+lane
    localparam logic [15:0] HAM_NEG = 16'h428E;
    // Matrix pair products: yy zz xy wz xz wy xx yz wx
    localparam logic [8:0][1:0] MAT_A =
        {2'd0, 2'd2, 2'd1, 2'd0, 2'd1, 2'd0, 2'd1, 2'd3, 2'd2};
    localparam logic [8:0][1:0] MAT_B =
        {2'd1, 2'd3, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd2};

    function automatic logic [D:0] f_clamp(input logic signed [EW-1:0] v);
        if (v > EMAX) begin
            return {1'b1, DMAXU};
        end else if (v < EMIN) begin
            return {1'b1, DMINU};
        end
        return {1'b0, v[D-1:0]};
    endfunction

    // ---------------- squares for the norm ----------------
    logic signed [PW-1:0] n_sq [4];
    logic signed [PW-1:0] q_ext [4];
    logic                 r1_v;
    logic signed [PW-1:0] r1_sq [4];
    qau_pkg::t_ctrl       r1_ctrl;
    logic [3:0][D-1:0]    r1_a, r1_b;
    logic [D-1:0]         r1_s;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q_ext[i] = (i_ctrl.op == qau_pkg::OP_QDIV) ? PW'($signed(i_b[i]))
                                                       : PW'($signed(i_a[i]));
            n_sq[i]  = q_ext[i] * q_ext[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq   <= n_sq;
            r1_ctrl <= i_ctrl;
            r1_a    <= i_a;
            r1_b    <= i_b;
            r1_s    <= i_s;
        end
    end

    // ---------------- divider and root setup ----------------
    logic [NW-1:0]        norm;
    logic [D-1:0]         s_abs;
    logic [D-1:0]         src, nmag;
    logic [NW-1:0]        den;
    logic [3:0][QW-1:0]   num;
    logic [3:0]           neg;
    logic [2*SQ-1:0]      rad;
    qau_pkg::t_ctrl       ctrl2;
    logic                 is_sdiv;

    always_comb begin
        norm = NW'(r1_sq[0][PW-1:F]) + NW'(r1_sq[1][PW-1:F])
             + NW'(r1_sq[2][PW-1:F]) + NW'(r1_sq[3][PW-1:F]);
        is_sdiv = (r1_ctrl.op == qau_pkg::OP_SDIV);
        s_abs   = r1_s[D-1] ? (~r1_s + 1'b1) : r1_s;
        den     = is_sdiv ? NW'(s_abs) : norm;
        src     = '0;
        nmag    = '0;
        for (int i = 0; i < 4; i++) begin
            src    = (r1_ctrl.op == qau_pkg::OP_QDIV) ? r1_b[i] : r1_a[i];
            nmag   = src[D-1] ? (~src + 1'b1) : src;
            num[i] = {nmag, {F{1'b0}}};
            // the inverse negates the vector part of the numerator
            if (!is_sdiv && i != 0) begin
                neg[i] = !src[D-1];
            end else begin
                neg[i] = src[D-1];
            end
            neg[i] = neg[i] ^ (is_sdiv && r1_s[D-1]);
        end
        rad   = {1'b0, norm, {F{1'b0}}};
        ctrl2 = r1_ctrl;
        if ((r1_ctrl.op == qau_pkg::OP_QDIV || r1_ctrl.op == qau_pkg::OP_INV)
            && norm == '0) begin
            ctrl2.divz = 1'b1;
        end
    end

    logic                d_v;
    logic [3:0][QW-1:0]  d_quo;
    logic [SQ-1:0]       d_root;
    logic [SIDE_W-1:0]   d_side;
    qau_pkg::t_ctrl      d_ctrl;
    logic [3:0][D-1:0]   d_a, d_b;
    logic [D-1:0]        d_s;
    logic [3:0]          d_neg;

    qau_divsqrt #(
        .D      (D),
        .F      (F),
        .SIDE_W (SIDE_W)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r1_v),
        .i_num   (num),
        .i_den   (den),
        .i_rad   (rad),
        .i_side  ({ctrl2, r1_a, r1_b, r1_s, neg}),
        .o_valid (d_v),
        .o_quo   (d_quo),
        .o_root  (d_root),
        .o_side  (d_side)
    );

    assign {d_ctrl, d_a, d_b, d_s, d_neg} = d_side;

    // ---------------- sign and clamp of quotients and root ----------------
    logic [3:0][D-1:0]  n_val;
    logic               sat_div, sat_root;
    qau_pkg::t_ctrl     ctrl3;
    logic               r3_v;
    qau_pkg::t_ctrl     r3_ctrl;
    logic [3:0][D-1:0]  r3_val, r3_a, r3_b;
    logic [D-1:0]       r3_s;

    always_comb begin
        sat_div = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (d_neg[i]) begin
                if (d_quo[i] > QW'(DMINU)) begin
                    n_val[i] = DMINU;
                    sat_div  = 1'b1;
                end else begin
                    n_val[i] = ~d_quo[i][D-1:0] + 1'b1;
                end
            end else begin
                if (d_quo[i] > QW'(DMAXU)) begin
                    n_val[i] = DMAXU;
                    sat_div  = 1'b1;
                end else begin
                    n_val[i] = d_quo[i][D-1:0];
                end
            end
        end
        sat_root = (d_root > SQ'(DMAXU));
        ctrl3    = d_ctrl;
        case (d_ctrl.op)
            qau_pkg::OP_QDIV, qau_pkg::OP_SDIV, qau_pkg::OP_INV: begin
                ctrl3.sat = d_ctrl.sat | sat_div;
            end
            qau_pkg::OP_MAG: begin
                n_val[0]  = sat_root ? DMAXU : d_root[D-1:0];
                ctrl3.sat = d_ctrl.sat | sat_root;
            end
            default: begin
                ctrl3.sat = d_ctrl.sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ctrl <= ctrl3;
            r3_val  <= n_val;
            r3_a    <= d_a;
            r3_b    <= d_b;
            r3_s    <= d_s;
        end
    end

    // ---------------- product array ----------------
    logic [D-1:0]         ma [16];
    logic [D-1:0]         mb [16];
    logic signed [PW-1:0] n_p [16];
    logic                 r4_v;
    qau_pkg::t_ctrl       r4_ctrl;
    logic signed [PW-1:0] r4_p [16];
    logic [3:0][D-1:0]    r4_val, r4_a, r4_b;

    always_comb begin
        logic [1:0] li;
        logic [1:0] lk;
        li = '0;
        lk = '0;
        for (int j = 0; j < 16; j++) begin
            li = 2'(j % 4);
            lk = 2'(j / 4);
            case (r3_ctrl.op)
                qau_pkg::OP_SCALE: begin
                    ma[j] = r3_a[li];
                    mb[j] = r3_s;
                end
                qau_pkg::OP_MATRIX: begin
                    if (j < 9) begin
                        ma[j] = r3_a[MAT_A[j]];
                        mb[j] = r3_a[MAT_B[j]];
                    end else begin
                        ma[j] = '0;
                        mb[j] = '0;
                    end
                end
                qau_pkg::OP_QDIV: begin
                    ma[j] = r3_a[li];
                    mb[j] = r3_val[li ^ lk];
                end
                default: begin
                    ma[j] = r3_a[li];
                    mb[j] = r3_b[li ^ lk];
                end
            endcase
            n_p[j] = PW'($signed(ma[j])) * PW'($signed(mb[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ctrl <= r3_ctrl;
            r4_p    <= n_p;
            r4_val  <= r3_val;
            r4_a    <= r3_a;
            r4_b    <= r3_b;
        end
    end

    // ---------------- final sums, clamp and status ----------------
    logic signed [EW-1:0] fq [16];
    logic signed [EW-1:0] ea [4];
    logic signed [EW-1:0] eb [4];
    logic signed [EW-1:0] val [9];
    logic signed [EW-1:0] acc;
    logic [D:0]           cl;
    logic                 sat_any;

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            fq[j] = EW'(r4_p[j] >>> F);
        end
        for (int i = 0; i < 4; i++) begin
            ea[i] = EW'($signed(r4_a[i]));
            eb[i] = EW'($signed(r4_b[i]));
        end
        for (int i = 0; i < 9; i++) begin
            val[i] = '0;
        end
        acc = '0;
        case (r4_ctrl.op)
            qau_pkg::OP_ADD: begin
                for (int i = 0; i < 4; i++) val[i] = ea[i] + eb[i];
            end
            qau_pkg::OP_SUB: begin
                for (int i = 0; i < 4; i++) val[i] = ea[i] - eb[i];
            end
            qau_pkg::OP_MUL, qau_pkg::OP_QDIV: begin
                for (int k = 0; k < 4; k++) begin
                    acc = '0;
                    for (int i = 0; i < 4; i++) begin
                        acc = HAM_NEG[4*k+i] ? acc - fq[4*k+i] : acc + fq[4*k+i];
                    end
                    val[k] = acc;
                end
            end
            qau_pkg::OP_SCALE: begin
                for (int i = 0; i < 4; i++) val[i] = fq[i];
            end
            qau_pkg::OP_SDIV, qau_pkg::OP_INV: begin
                for (int i = 0; i < 4; i++) val[i] = EW'($signed(r4_val[i]));
            end
            qau_pkg::OP_MAG: begin
                val[0] = EW'($signed(r4_val[0]));
            end
            qau_pkg::OP_CONJ: begin
                val[0] = ea[0];
                for (int i = 1; i < 4; i++) val[i] = -ea[i];
            end
            qau_pkg::OP_MATRIX: begin
                val[0] = ONE_E - (fq[0] <<< 1) - (fq[1] <<< 1);
                val[1] = (fq[2] <<< 1) + (fq[3] <<< 1);
                val[2] = (fq[4] <<< 1) - (fq[5] <<< 1);
                val[3] = (fq[2] <<< 1) - (fq[3] <<< 1);
                val[4] = ONE_E - (fq[6] <<< 1) - (fq[1] <<< 1);
                val[5] = (fq[7] <<< 1) + (fq[8] <<< 1);
                val[6] = (fq[4] <<< 1) + (fq[5] <<< 1);
                val[7] = (fq[7] <<< 1) - (fq[8] <<< 1);
                val[8] = ONE_E - (fq[6] <<< 1) - (fq[0] <<< 1);
            end
            default: begin
                acc = '0;
            end
        endcase

        sat_any = r4_ctrl.sat;
        cl      = '0;
        for (int i = 0; i < 9; i++) begin
            cl       = f_clamp(val[i]);
            o_res[i] = cl[D-1:0];
            sat_any  = sat_any | cl[D];
        end

        // A zero divisor wins over saturation and clears the result
        if (r4_ctrl.divz) begin
            o_status = qau_pkg::ST_DIVZ;
            o_res    = '0;
        end else if (sat_any) begin
            o_status = qau_pkg::ST_SAT;
        end else begin
            o_status = qau_pkg::ST_OK;
        end
    end

    assign o_valid = r4_v;

endmodule

>>> rtl/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit.
// Requests enter through a queue interface: drive the opcode, quaternions a and
// b and the scalar, raise push; the request is taken at a clock edge where push
// is high and full is low. Results leave through a second queue: while empty is
// low the oldest result (status, out_0..out_8) is on the ports, and pop at a
// clock edge with empty low takes it. One result per request, in order.
// A request passes the squares stage, the restoring divider and square root
// that resolve one quotient bit per stage for all four lanes at once, the sign
// and clamp stage and the product stage; the default format is Q16.16.
// Throughput, while the result queue has room, is one request per cycle: all
// stages are pipelined; a request of any opcode may follow in the next cycle.
// While the result queue is full the whole back pipeline holds; the request
// queue keeps taking requests until it fills too, then full rises.
// Reset empties both queues and clears all pipeline valid bits; no clearing
// pass follows, the unit takes requests as soon as reset is released.
module quaternion_arithmetic_unit #(
    parameter int DATA_WIDTH = qau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [3:0]                   i_opcode,
    input  logic signed [DATA_WIDTH-1:0] i_a_w,
    input  logic signed [DATA_WIDTH-1:0] i_a_x,
    input  logic signed [DATA_WIDTH-1:0] i_a_y,
    input  logic signed [DATA_WIDTH-1:0] i_a_z,
    input  logic signed [DATA_WIDTH-1:0] i_b_w,
    input  logic signed [DATA_WIDTH-1:0] i_b_x,
    input  logic signed [DATA_WIDTH-1:0] i_b_y,
    input  logic signed [DATA_WIDTH-1:0] i_b_z,
    input  logic signed [DATA_WIDTH-1:0] i_scalar,
    output logic                         empty,
    input  logic                         pop,
    output logic [1:0]                   o_status,
    output logic signed [DATA_WIDTH-1:0] o_out_0,
    output logic signed [DATA_WIDTH-1:0] o_out_1,
    output logic signed [DATA_WIDTH-1:0] o_out_2,
    output logic signed [DATA_WIDTH-1:0] o_out_3,
    output logic signed [DATA_WIDTH-1:0] o_out_4,
    output logic signed [DATA_WIDTH-1:0] o_out_5,
    output logic signed [DATA_WIDTH-1:0] o_out_6,
    output logic signed [DATA_WIDTH-1:0] o_out_7,
    output logic signed [DATA_WIDTH-1:0] o_out_8
);

    localparam int D  = DATA_WIDTH;
    localparam int RW = 2 + 9 * D;

    logic [3:0][D-1:0]  in_a, in_b;
    logic               f_valid;
    qau_pkg::t_ctrl     f_ctrl;
    logic [3:0][D-1:0]  f_a, f_b;
    logic [D-1:0]       f_s;
    logic               en;
    logic               b_valid;
    qau_pkg::t_status   b_status;
    logic [8:0][D-1:0]  b_res;
    logic               res_full;
    logic [RW-1:0]      res_data;

    assign in_a = {i_a_z, i_a_y, i_a_x, i_a_w};
    assign in_b = {i_b_z, i_b_y, i_b_x, i_b_w};

    // Advance the back pipeline whenever the result queue has room
    assign en = !res_full;

    qau_front #(
        .D     (D),
        .DEPTH (qau_pkg::QUEUE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_opcode (i_opcode),
        .i_a      (in_a),
        .i_b      (in_b),
        .i_s      (i_scalar),
        .o_valid  (f_valid),
        .i_take   (en),
        .o_ctrl   (f_ctrl),
        .o_a      (f_a),
        .o_b      (f_b),
        .o_s      (f_s)
    );

    qau_back #(
        .D (D),
        .F (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (f_valid),
        .i_ctrl   (f_ctrl),
        .i_a      (f_a),
        .i_b      (f_b),
        .i_s      (f_s),
        .o_valid  (b_valid),
        .o_status (b_status),
        .o_res    (b_res)
    );

    qau_fifo #(
        .W     (RW),
        .DEPTH (qau_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (en && b_valid),
        .i_data  ({b_status, b_res}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data),
        .o_empty (empty)
    );

    assign o_status = res_data[RW-1 -: 2];
    assign o_out_0  = res_data[0*D +: D];
    assign o_out_1  = res_data[1*D +: D];
    assign o_out_2  = res_data[2*D +: D];
    assign o_out_3  = res_data[3*D +: D];
    assign o_out_4  = res_data[4*D +: D];
    assign o_out_5  = res_data[5*D +: D];
    assign o_out_6  = res_data[6*D +: D];
    assign o_out_7  = res_data[7*D +: D];
    assign o_out_8  = res_data[8*D +: D];

`ifndef SYNTH
    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_status == qau_pkg::ST_DIVZ |->
            o_out_0 == '0 && o_out_1 == '0 && o_out_2 == '0 && o_out_3 == '0 &&
            o_out_4 == '0 && o_out_5 == '0 && o_out_6 == '0 && o_out_7 == '0 &&
            o_out_8 == '0)
        else $error("division-by-zero result carries nonzero data");
`endif

endmodule
